// ===== sv/mfbp_pkg.sv =====
package mfbp_pkg;

    localparam int CODE_W   = 64;
    localparam int LEN_W    = 7;
    localparam int TOTAL_W  = 32;
    localparam int WIN_W    = CODE_W + 8;
    localparam int WIN_BYTES = WIN_W / 8;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    // one classified word, code already left aligned
    typedef struct packed {
        logic               mode;
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
        logic [TOTAL_W-1:0] total;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== sv/mfbp_in_if.sv =====
interface mfbp_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [mfbp_pkg::CODE_W-1:0]  code_value;
    logic [mfbp_pkg::LEN_W-1:0]   code_length;

    modport source (output valid, output mode, output code_value, output code_length,
                    input ready);
    modport sink (input valid, input mode, input code_value, input code_length,
                  output ready);
endinterface

// ===== sv/mfbp_out_if.sv =====
interface mfbp_out_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    out_byte;
    logic [3:0]                    valid_bits;
    logic                          last;
    logic [mfbp_pkg::TOTAL_W-1:0]  total_bits;

    modport source (output valid, output out_byte, output valid_bits, output last,
                    output total_bits, input ready);
    modport sink (input valid, input out_byte, input valid_bits, input last,
                  input total_bits, output ready);
endinterface

// ===== sv/mfbp_front.sv =====
module mfbp_front #(
    parameter int MAX_CODE_BITS = 64,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    mfbp_in_if.sink          in_ch,
    input  logic             q_ready,
    output logic             push,
    output mfbp_pkg::entry_t entry
);

    localparam logic [mfbp_pkg::LEN_W-1:0] MaxLen = mfbp_pkg::LEN_W'(MAX_CODE_BITS);

    logic [COUNT_WIDTH-1:0]        total_reg;
    logic [COUNT_WIDTH-1:0]        total_next;
    logic [mfbp_pkg::LEN_W-1:0]    len_sat;
    logic [mfbp_pkg::LEN_W-1:0]    shift_amt;
    logic                          is_flush;
    logic                          accept;
    logic [63:0]                   total_ext;

    assign in_ch.ready = q_ready;
    assign accept      = in_ch.valid && q_ready;
    assign is_flush    = (in_ch.mode == mfbp_pkg::MODE_FLUSH);

    assign len_sat    = (in_ch.code_length > MaxLen) ? MaxLen : in_ch.code_length;
    assign shift_amt  = mfbp_pkg::LEN_W'(mfbp_pkg::CODE_W) - len_sat;
    assign total_next = total_reg + COUNT_WIDTH'(len_sat);

    // zero-length appends leave no trace
    assign push = accept && (is_flush || (len_sat != '0));

    assign total_ext = 64'(is_flush ? total_reg : total_next);

    always_comb
    begin
        entry.mode  = in_ch.mode;
        // left shift drops everything above the code length
        entry.code  = in_ch.code_value << shift_amt;
        entry.len   = len_sat;
        entry.total = total_ext[mfbp_pkg::TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (accept && !is_flush)
        begin
            total_reg <= total_next;
        end
    end

endmodule

// ===== sv/mfbp_queue.sv =====
module mfbp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mfbp_pkg::entry_t        push_entry,
    input  logic                    pop,
    output mfbp_pkg::entry_t        head,
    output mfbp_pkg::queue_status_t status
);

    mfbp_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/mfbp_back.sv =====
module mfbp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mfbp_pkg::entry_t        head,
    input  mfbp_pkg::queue_status_t q_status,
    output logic                    pop,
    mfbp_out_if.source              out_ch
);

    logic [7:0]                   partial_reg;
    logic [2:0]                   fill_reg;
    logic                         active_reg;
    logic [mfbp_pkg::WIN_W-1:0]   win_reg;
    logic [3:0]                   cnt_reg;
    logic [3:0]                   vb_reg;
    logic [mfbp_pkg::TOTAL_W-1:0] tot_reg;

    logic [7:0]                   partial_next;
    logic [2:0]                   fill_next;
    logic [mfbp_pkg::WIN_W-1:0]   win_load;
    logic [3:0]                   cnt_load;
    logic [3:0]                   vb_load;
    logic [mfbp_pkg::LEN_W-1:0]   nbits;
    logic [mfbp_pkg::WIN_BYTES-1:0][7:0] win_bytes;
    logic [3:0]                   tail_idx;

    logic                         ov_reg;
    logic                         out_free;
    logic                         emit;
    logic                         load;

    assign out_free = !ov_reg || out_ch.ready;
    assign emit     = active_reg && out_free;
    assign load     = !q_status.empty && (!active_reg || (emit && (cnt_reg == 4'd1)));
    assign pop      = load;

    assign nbits     = mfbp_pkg::LEN_W'(fill_reg) + head.len;
    // new code starts right below the bits already held in the partial byte
    assign win_bytes = ({partial_reg, {mfbp_pkg::CODE_W{1'b0}}}
                       | ({head.code, 8'b0} >> fill_reg));
    assign tail_idx  = 4'(mfbp_pkg::WIN_BYTES - 1) - nbits[6:3];

    always_comb
    begin
        if (head.mode == mfbp_pkg::MODE_FLUSH)
        begin
            win_load     = {partial_reg, {mfbp_pkg::CODE_W{1'b0}}};
            cnt_load     = 4'd1;
            vb_load      = {1'b0, fill_reg};
            partial_next = 8'd0;
            fill_next    = 3'd0;
        end
        else
        begin
            win_load     = win_bytes;
            cnt_load     = nbits[6:3];
            vb_load      = 4'd8;
            // leftover bits sit right after the last full byte
            partial_next = win_bytes[tail_idx];
            fill_next    = nbits[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 8'd0;
            fill_reg    <= 3'd0;
            active_reg  <= 1'b0;
            cnt_reg     <= 4'd0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                partial_reg <= partial_next;
                fill_reg    <= fill_next;
                active_reg  <= (cnt_load != 4'd0);
                cnt_reg     <= cnt_load;
            end
            else if (emit)
            begin
                active_reg <= (cnt_reg != 4'd1);
                cnt_reg    <= cnt_reg - 4'd1;
            end

            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            win_reg <= win_load;
            vb_reg  <= vb_load;
            tot_reg <= head.total;
        end
        else if (emit)
        begin
            win_reg <= win_reg << 8;
        end

        if (emit)
        begin
            out_ch.out_byte   <= win_reg[mfbp_pkg::WIN_W-1 -: 8];
            out_ch.valid_bits <= vb_reg;
            out_ch.last       <= (cnt_reg == 4'd1);
            out_ch.total_bits <= tot_reg;
        end
    end

    assign out_ch.valid = ov_reg;

endmodule

// ===== sv/msb_first_bit_packer.sv =====
// msb-first bit packer
// in_ch takes one word per cycle while the queue has room: an append (mode 0) of
// code_length low bits of code_value, saturated to MAX_CODE_BITS, or a flush
// (mode 1) of the partial byte. out_ch gives packed bytes, first bit in bit 7; last
// marks the final byte that a word causes, valid_bits is 8 except on a flushed tail.
// total_bits is the running bit count after the word, wrapping at COUNT_WIDTH bits.
// a word occupies the byte emitter until its completed bytes are out; the
// emitter moves one byte per cycle while out_ch is ready, so a stream of 64-bit
// codes gives eight bytes per word and short codes run at one word per cycle.
// when the pipeline is empty, the first byte of a word passes through the queue
// write at the accepting edge, the window load and the output register.
// a two-entry queue sits between the classifier and the emitter; in_ch.ready
// drops only when it is full. a stalled out_ch holds its byte while the
// queue keeps taking words.
// reset clears the partial byte, fill level, bit total and all valid flags.
// zero-length appends produce no byte and change nothing.
module msb_first_bit_packer #(
    parameter int MAX_CODE_BITS = 64,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    mfbp_in_if.sink     in_ch,
    mfbp_out_if.source  out_ch
);

    mfbp_pkg::entry_t        push_entry;
    mfbp_pkg::entry_t        head;
    mfbp_pkg::queue_status_t q_status;
    logic                    push;
    logic                    pop;

    mfbp_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_ready (!q_status.full),
        .push    (push),
        .entry   (push_entry)
    );

    mfbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    mfbp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .out_ch   (out_ch)
    );

    // only a flushed tail may carry fewer than eight bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.last) |-> (out_ch.valid_bits == 4'd8))
        else $error("short byte before the last one");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.valid_bits <= 4'd8))
        else $error("valid_bits above eight");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue overflow");

    // bytes of one word share one bit total
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last)
        |=> (!out_ch.valid || (out_ch.total_bits == $past(out_ch.total_bits))))
        else $error("bit total changed within a word");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    typedef struct {
        logic [7:0]                   out_byte;
        logic [3:0]                   valid_bits;
        logic                         last;
        logic [mfbp_pkg::TOTAL_W-1:0] total_bits;
    } packed_byte_t;

    logic clk;
    logic rst_n;

    mfbp_in_if  in_ch ();
    mfbp_out_if out_ch ();

    msb_first_bit_packer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // bytes the packer should still produce, oldest first
    packed_byte_t pending_bytes[$];

    // shadow of the packer state
    logic [7:0]                   shadow_partial;
    int                           shadow_fill;
    logic [mfbp_pkg::TOTAL_W-1:0] shadow_total;

    int          send_idle_pct;
    int          sink_stall_pct;
    int          stall_left;
    int unsigned mismatches;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void pack_word(logic m, logic [mfbp_pkg::CODE_W-1:0] v,
                                      logic [mfbp_pkg::LEN_W-1:0] l);
        packed_byte_t burst[$];
        packed_byte_t b;
        int len;
        if (m == mfbp_pkg::MODE_FLUSH)
        begin
            b.out_byte   = shadow_partial;
            b.valid_bits = 4'(shadow_fill);
            b.last       = 1'b1;
            b.total_bits = shadow_total;
            pending_bytes.push_back(b);
            shadow_partial = '0;
            shadow_fill    = 0;
            return;
        end
        len = (l > 7'd64) ? 64 : int'(l);
        shadow_total = shadow_total + mfbp_pkg::TOTAL_W'(len);
        // bits above len are never read, so the value is masked implicitly
        for (int i = len - 1; i >= 0; i--)
        begin
            shadow_partial[7 - shadow_fill] = v[i];
            shadow_fill++;
            if (shadow_fill == 8)
            begin
                b.out_byte   = shadow_partial;
                b.valid_bits = 4'd8;
                b.last       = 1'b0;
                b.total_bits = shadow_total;
                burst.push_back(b);
                shadow_partial = '0;
                shadow_fill    = 0;
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k])
            pending_bytes.push_back(burst[k]);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // byte side: random stalls, or a counted hold-off when stall_left is set
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    initial
    begin
        packed_byte_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_bytes.size() == 0)
                    report_mismatch("unexpected byte", 64'(out_ch.out_byte), 64'd0);
                else
                begin
                    want = pending_bytes.pop_front();
                    if (out_ch.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 64'(out_ch.out_byte),
                                        64'(want.out_byte));
                    if (out_ch.valid_bits !== want.valid_bits)
                        report_mismatch("valid_bits", 64'(out_ch.valid_bits),
                                        64'(want.valid_bits));
                    if (out_ch.last !== want.last)
                        report_mismatch("last", 64'(out_ch.last), 64'(want.last));
                    if (out_ch.total_bits !== want.total_bits)
                        report_mismatch("total_bits", 64'(out_ch.total_bits),
                                        64'(want.total_bits));
                end
            end
        end
    end

    // valid stays high after acceptance so back-to-back words need no second
    // assignment in one step; callers drop it through wait_drained
    task automatic send_word(logic m, logic [mfbp_pkg::CODE_W-1:0] v,
                             logic [mfbp_pkg::LEN_W-1:0] l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= m;
        in_ch.code_value  <= v;
        in_ch.code_length <= l;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pack_word(m, v, l);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        send_word(mfbp_pkg::MODE_APPEND, '1, 7'd0);
        send_word(mfbp_pkg::MODE_FLUSH, '0, 7'd0);
        send_word(mfbp_pkg::MODE_APPEND, 64'h1, 7'd1);
        send_word(mfbp_pkg::MODE_FLUSH, '1, 7'd127);
        send_word(mfbp_pkg::MODE_APPEND, '1, 7'd64);
        send_word(mfbp_pkg::MODE_APPEND, 64'h0123_4567_89ab_cdef, 7'd64);
        send_word(mfbp_pkg::MODE_APPEND, 64'hfedc_ba98_7654_3210, 7'd127);
        send_word(mfbp_pkg::MODE_APPEND, 64'h8000_0000_0000_0001, 7'd65);
        // upper bits must be ignored
        send_word(mfbp_pkg::MODE_APPEND, 64'hffff_ffff_ffff_fff5, 7'd3);
        send_word(mfbp_pkg::MODE_APPEND, 64'h15, 7'd5);
        send_word(mfbp_pkg::MODE_APPEND, 64'h7f, 7'd7);
        send_word(mfbp_pkg::MODE_APPEND, 64'haaaa_5555_cccc_3333, 7'd64);
        send_word(mfbp_pkg::MODE_FLUSH, 64'h1234, 7'd64);
        send_word(mfbp_pkg::MODE_FLUSH, '0, 7'd0);
        send_word(mfbp_pkg::MODE_APPEND, 64'ha5, 7'd8);
        send_word(mfbp_pkg::MODE_APPEND, '0, 7'd63);
        send_word(mfbp_pkg::MODE_APPEND, 64'h1, 7'd1);
        // low half of a wide value must keep all 32 bits
        send_word(mfbp_pkg::MODE_APPEND, 64'hffff_ffff_dead_beef, 7'd32);
        send_word(mfbp_pkg::MODE_APPEND, '0, 7'd64);
        send_word(mfbp_pkg::MODE_APPEND, 64'h3, 7'd2);
        send_word(mfbp_pkg::MODE_FLUSH, '1, 7'd1);
        wait_drained();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        int done;
        int r;
        logic m;
        logic [mfbp_pkg::CODE_W-1:0] v;
        logic [mfbp_pkg::LEN_W-1:0] l;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        done = 0;
        while (done < count)
        begin
            r = int'($urandom_range(0, 99));
            m = mfbp_pkg::MODE_APPEND;
            v = {$urandom, $urandom};
            if (r < 8)
            begin
                m = mfbp_pkg::MODE_FLUSH;
                l = 7'($urandom_range(0, 127));
            end
            else if (r < 14)
                l = 7'd0;
            else if (r < 26)
                l = 7'($urandom_range(65, 127));
            else if (r < 40)
                l = 7'd64;
            else if (r < 70)
                l = 7'($urandom_range(1, 8));
            else
                l = 7'($urandom_range(1, 63));
            r = int'($urandom_range(0, 9));
            if (r == 0)
                v = '1;
            else if (r == 1)
                v = '0;
            send_word(m, v, l);
            if (m == mfbp_pkg::MODE_FLUSH || l != 0)
                done++;
        end
        wait_drained();
    endtask

    // hold the byte side long enough that the queue fills and in_ch.ready drops
    task automatic test_output_hold();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        stall_left     = 300;
        for (int i = 0; i < 30; i++)
            send_word(mfbp_pkg::MODE_APPEND, {$urandom, $urandom},
                      (i % 3 == 0) ? 7'd64 : 7'd13);
        send_word(mfbp_pkg::MODE_FLUSH, '0, 7'd0);
        wait_drained();
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 31;
        sink_stall_pct = 31;
        for (int i = 0; i < 4; i++)
            send_word(mfbp_pkg::MODE_APPEND, {$urandom, $urandom},
                      7'($urandom_range(1, 64)));
        wait_drained();
        repeat (20) @(posedge clk);
        send_word(mfbp_pkg::MODE_FLUSH, {$urandom, $urandom}, 7'($urandom_range(0, 127)));
        send_word(mfbp_pkg::MODE_APPEND, {$urandom, $urandom}, 7'd64);
        wait_drained();
    endtask

    initial
    begin
        in_ch.valid       <= 1'b0;
        in_ch.mode        <= mfbp_pkg::MODE_APPEND;
        in_ch.code_value  <= '0;
        in_ch.code_length <= '0;
        rst_n          <= 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        stall_left     = 0;
        mismatches     = 0;
        shadow_partial = '0;
        shadow_fill    = 0;
        shadow_total   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 64);
        test_random_phase(76, 0, 64);
        test_output_hold();
        test_random_phase(0, 76, 64);
        test_drain_pause();
        test_random_phase(31, 31, 64);

        // let any word still inside the pipeline show up as an unexpected byte
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mfbp_pkg.sv
sv/mfbp_in_if.sv
sv/mfbp_out_if.sv
sv/mfbp_front.sv
sv/mfbp_queue.sv
sv/mfbp_back.sv
sv/msb_first_bit_packer.sv
tb/sv/tb_top.sv
